// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tria_pkg.sv
// shared constants, types and codes of the interval assigner
package tria_pkg;

   // occupancy store geometry
   localparam int SLOT_COUNT = 2048;
   localparam int SLOT_AW    = $clog2(SLOT_COUNT);
   localparam int SLOT_CW    = SLOT_AW + 1;

   // transaction field widths
   localparam int START_W  = 11;
   localparam int END_W    = 12;
   localparam int ID_W     = 10;
   localparam int ASSIGN_W = 2;

   // command codes
   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_PLACE = 1'b1;

   // busy bits of one slot
   localparam logic [1:0] BUSY_NONE   = 2'b00;
   localparam logic [1:0] BUSY_FIRST  = 2'b01;
   localparam logic [1:0] BUSY_SECOND = 2'b10;

   typedef enum logic [ASSIGN_W-1:0] {
      ASSIGN_FIRST  = 2'd0,
      ASSIGN_SECOND = 2'd1,
      ASSIGN_REJECT = 2'd2
   } assign_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_DECIDE,
      ST_MARK,
      ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic clear_start;
      logic clear_step;
      logic scan_step;
      logic decide;
      logic mark_step;
      logic respond;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic range_empty;
      logic range_last;
      logic clear_last;
      logic reject;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: rtl/core/tria_datapath.sv
// occupancy store, slot address counter, scan/mark logic and result register
module tria_datapath
   import tria_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [START_W-1:0]  req_start_slot,
   input  logic [END_W-1:0]    req_end_slot,
   input  logic [ID_W-1:0]     req_item_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ASSIGN_W-1:0] rsp_assignment,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic                rsp_case_failed
);

   logic [1:0]          mem [SLOT_COUNT];
   logic [1:0]          rdata_ff;

   logic [SLOT_CW-1:0]  lo_ff, lo_in;
   logic [SLOT_CW-1:0]  hi_ff, hi_in;
   logic [ID_W-1:0]     id_ff;
   logic [SLOT_CW-1:0]  addr_ff, addr_in;
   logic [SLOT_CW-1:0]  addr_next;
   logic [1:0]          seen_ff, seen_in;
   logic [1:0]          seen_all;
   logic                scan_vld_ff;
   logic                wr_vld_ff;
   logic [SLOT_AW-1:0]  wr_addr_ff;
   logic [1:0]          mark_ff, mark_in;
   assign_type          assign_ff, assign_in;
   logic                failed_ff, failed_in;

   logic                mem_we;
   logic [SLOT_AW-1:0]  mem_waddr;
   logic [1:0]          mem_wdata;

   logic                rsp_valid_ff;
   logic [ASSIGN_W-1:0] rsp_assign_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic                rsp_failed_ff;

   // clamp the range to the store
   always_comb begin
      lo_in = SLOT_CW'(req_start_slot);
      if (req_end_slot > END_W'(SLOT_COUNT)) begin
         hi_in = SLOT_CW'(SLOT_COUNT);
      end else begin
         hi_in = SLOT_CW'(req_end_slot);
      end
   end

   assign addr_next = addr_ff + SLOT_CW'(1);

   // slot address counter
   always_comb begin
      addr_in = addr_ff;
      if (cmd.clear_start) begin
         addr_in = '0;
      end else if (cmd.load) begin
         addr_in = lo_in;
      end else if (cmd.decide) begin
         addr_in = lo_ff;
      end else if (cmd.clear_step || cmd.scan_step || cmd.mark_step) begin
         addr_in = addr_next;
      end
   end

   // busy bits seen so far, including the read still in flight
   assign seen_all = seen_ff | (scan_vld_ff ? rdata_ff : BUSY_NONE);

   always_comb begin
      seen_in = seen_ff;
      if (cmd.load) begin
         seen_in = BUSY_NONE;
      end else begin
         seen_in = seen_all;
      end
   end

   // greedy resource choice; a clear command resets the failure flag
   always_comb begin
      mark_in   = mark_ff;
      assign_in = assign_ff;
      failed_in = failed_ff;
      if (cmd.clear_start) begin
         failed_in = 1'b0;
      end else if (cmd.decide) begin
         if ((seen_all & BUSY_FIRST) == BUSY_NONE) begin
            assign_in = ASSIGN_FIRST;
            mark_in   = BUSY_FIRST;
         end else if ((seen_all & BUSY_SECOND) == BUSY_NONE) begin
            assign_in = ASSIGN_SECOND;
            mark_in   = BUSY_SECOND;
         end else begin
            assign_in = ASSIGN_REJECT;
            mark_in   = BUSY_NONE;
            failed_in = 1'b1;
         end
      end
   end

   // status toward the controller
   always_comb begin
      status.range_empty = (lo_ff >= hi_ff);
      status.range_last  = (addr_next == hi_ff);
      status.clear_last  = (addr_ff == SLOT_CW'(SLOT_COUNT - 1));
      status.reject      = ((seen_all & BUSY_FIRST) != BUSY_NONE) &&
                           ((seen_all & BUSY_SECOND) != BUSY_NONE);
      status.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

   // write port: clearing sweep or the delayed half of read-modify-write
   always_comb begin
      mem_we    = cmd.clear_step || wr_vld_ff;
      mem_waddr = cmd.clear_step ? addr_ff[SLOT_AW-1:0] : wr_addr_ff;
      mem_wdata = cmd.clear_step ? BUSY_NONE : (rdata_ff | mark_ff);
   end

   // occupancy store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff[SLOT_AW-1:0]];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         scan_vld_ff  <= 1'b0;
         wr_vld_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         scan_vld_ff <= cmd.scan_step;
         wr_vld_ff   <= cmd.mark_step;
         failed_ff   <= failed_in;
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         id_ff <= req_item_id;
      end
      seen_ff    <= seen_in;
      mark_ff    <= mark_in;
      assign_ff  <= assign_in;
      wr_addr_ff <= addr_ff[SLOT_AW-1:0];
      if (cmd.respond) begin
         rsp_assign_ff <= assign_ff;
         rsp_id_ff     <= id_ff;
         rsp_failed_ff <= failed_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_assignment  = rsp_assign_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_case_failed = rsp_failed_ff;

endmodule

// File: rtl/core/tria_ctrl.sv
// sequencer for clear sweep, scan pass, decision, mark pass and response
module tria_ctrl
   import tria_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_command,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = (state_ff == ST_IDLE) && req_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == CMD_CLEAR) ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.range_empty || status.range_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.range_empty || status.reject) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            if (status.range_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.load        = accept && (req_command == CMD_PLACE);
            cmd.clear_start = accept && (req_command == CMD_CLEAR);
         end
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_SCAN:  cmd.scan_step  = !status.range_empty;
         ST_DECIDE: cmd.decide    = 1'b1;
         ST_MARK:  cmd.mark_step  = 1'b1;
         ST_DONE:  cmd.respond    = status.rsp_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   // state register; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/two_resource_interval_assigner.sv
// top level of the two-resource greedy interval assigner
// A place transaction clamps the end of its range to the store size. Every slot of the
// range is read once in the scan pass and read and rewritten once in the mark pass, one
// slot per cycle through the single read port of the occupancy memory. A decision state
// and the loading of the output register come on top; a rejected transaction skips the
// mark pass and an empty range skips both passes. The block is idle again, ready for its
// next transaction, as soon as the response is loaded. The output register is loaded only
// once the previous response has left, so a stalled response holds back the next one. A
// clear transaction produces no response and sweeps all 2048 slots at one per cycle. The
// same sweep runs right after reset, and req_stall stays high until it ends. One
// transaction is in work at a time, but a finished response may wait in the output
// register while the next one is taken.
module two_resource_interval_assigner
   import tria_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [START_W-1:0]  req_start_slot,
   input  logic [END_W-1:0]    req_end_slot,
   input  logic [ID_W-1:0]     req_item_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ASSIGN_W-1:0] rsp_assignment,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic                rsp_case_failed
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   tria_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // store and result path
   tria_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_start_slot  (req_start_slot),
      .req_end_slot    (req_end_slot),
      .req_item_id     (req_item_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_assignment  (rsp_assignment),
      .rsp_result_id   (rsp_result_id),
      .rsp_case_failed (rsp_case_failed)
   );

endmodule

// File: rtl/core/tria_checker.sv
// port-level checker for the interval assigner and its bind
`include "assert_macros.svh"

module tria_checker
   import tria_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_command,
   input logic [START_W-1:0]  req_start_slot,
   input logic [END_W-1:0]    req_end_slot,
   input logic [ID_W-1:0]     req_item_id,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [ASSIGN_W-1:0] rsp_assignment,
   input logic [ID_W-1:0]     rsp_result_id,
   input logic                rsp_case_failed
);

   // a stalled response keeps its valid and payload
   `ASSERT_IMPLY(a_rsp_hold, clock, reset, $past(!reset) && $past(rsp_valid && rsp_stall), rsp_valid && $stable(rsp_assignment) && $stable(rsp_result_id) && $stable(rsp_case_failed), "stalled response changed")

   // a rejected interval always shows the failure flag
   `ASSERT_IMPLY(a_reject_flag, clock, reset, rsp_valid && (rsp_assignment == ASSIGN_REJECT), rsp_case_failed, "reject without failure flag")

   // no unused assignment code leaves the block
   `ASSERT_IMPLY(a_assign_code, clock, reset, rsp_valid, (rsp_assignment == ASSIGN_FIRST) || (rsp_assignment == ASSIGN_SECOND) || (rsp_assignment == ASSIGN_REJECT), "bad assignment code")

   // every accepted transaction raises req_stall, so no two are accepted back to back
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted two transactions back to back")

endmodule

bind two_resource_interval_assigner tria_checker u_tria_checker (.*);

// File: test/two_resource_interval_assigner_tb.sv
`timescale 1ns / 1ps
// testbench of the two-resource interval assigner, checked against a local occupancy model
module two_resource_interval_assigner_tb;
   import tria_pkg::*;

   typedef struct {
      assign_type           assignment;
      logic [ID_W-1:0]      id;
      logic                 failed;
   } placement_type;

   logic                clock;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic                req_command     = CMD_CLEAR;
   logic [START_W-1:0]  req_start_slot  = '0;
   logic [END_W-1:0]    req_end_slot    = '0;
   logic [ID_W-1:0]     req_item_id     = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [ASSIGN_W-1:0] rsp_assignment;
   logic [ID_W-1:0]     rsp_result_id;
   logic                rsp_case_failed;

   // occupancy model and expected placements
   logic [1:0]    busy_map [SLOT_COUNT];
   logic          sticky_fail;
   placement_type expected_placements [$];

   int unsigned   gap_max      = 6;
   int unsigned   stall_max    = 6;
   int unsigned   stall_left   = 0;
   int unsigned   error_count  = 0;
   longint        cycle_count  = 0;
   longint        cycle_budget = 2100;
   longint        cycle_limit  = 4 * 2100 + 50000;

   two_resource_interval_assigner dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_start_slot  (req_start_slot),
      .req_end_slot    (req_end_slot),
      .req_item_id     (req_item_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_assignment  (rsp_assignment),
      .rsp_result_id   (rsp_result_id),
      .rsp_case_failed (rsp_case_failed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // clear the occupancy model
   function automatic void clear_model();
      foreach (busy_map[s]) busy_map[s] = BUSY_NONE;
      sticky_fail = 1'b0;
   endfunction

   // scan the range, pick a resource and mark it in the model
   function automatic placement_type predict_placement(logic [START_W-1:0] lo,
                                                       logic [END_W-1:0] hi,
                                                       logic [ID_W-1:0] id);
      placement_type p;
      int unsigned   top;
      logic [1:0]    seen;
      logic [1:0]    mark;
      top  = (hi > SLOT_COUNT) ? SLOT_COUNT : hi;
      seen = BUSY_NONE;
      for (int unsigned s = lo; s < top; s++) seen |= busy_map[s];
      if ((seen & BUSY_FIRST) == BUSY_NONE) begin
         p.assignment = ASSIGN_FIRST;
         mark = BUSY_FIRST;
      end else if ((seen & BUSY_SECOND) == BUSY_NONE) begin
         p.assignment = ASSIGN_SECOND;
         mark = BUSY_SECOND;
      end else begin
         p.assignment = ASSIGN_REJECT;
         mark = BUSY_NONE;
         sticky_fail = 1'b1;
      end
      for (int unsigned s = lo; s < top; s++) busy_map[s] |= mark;
      p.id     = id;
      p.failed = sticky_fail;
      return p;
   endfunction

   // send one transaction and record what it should produce
   task automatic issue_request(input logic cmd, input logic [START_W-1:0] lo,
                                input logic [END_W-1:0] hi, input logic [ID_W-1:0] id);
      int unsigned   gap;
      int unsigned   span;
      placement_type want;
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_start_slot <= lo;
      req_end_slot   <= hi;
      req_item_id    <= id;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      span = ((hi > SLOT_COUNT) ? SLOT_COUNT : hi);
      span = (span > lo) ? span - lo : 0;
      if (cmd == CMD_CLEAR) begin
         clear_model();
         cycle_budget += SLOT_COUNT + 30;
      end else begin
         want = predict_placement(lo, hi, id);
         expected_placements.insert(expected_placements.size(), want);
         cycle_budget += 2 * span + 30;
      end
      cycle_limit = 4 * cycle_budget + 50000;
   endtask

   // hold off the sender until every expected result is back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
   endtask

   // mostly short spans, a few long, rarely the whole store
   function automatic int unsigned draw_span_length();
      int unsigned r;
      r = $urandom_range(0, 63);
      if (r == 0) return SLOT_COUNT;
      if (r < 4) return $urandom_range(25, 300);
      return $urandom_range(0, 24);
   endfunction

   // receiver stall: each result waits its drawn number of cycles
   always @(negedge clock) begin
      if (rsp_valid && stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      placement_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_placements.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected result: assignment %0d result_id %0d case_failed %0d",
                        rsp_assignment, rsp_result_id, rsp_case_failed);
         end else begin
            want = expected_placements.pop_front();
            if (rsp_assignment !== want.assignment || rsp_result_id !== want.id ||
                rsp_case_failed !== want.failed) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: assignment exp %0d got %0d,",
                           want.assignment, rsp_assignment,
                           " result_id exp %0d got %0d,", want.id, rsp_result_id,
                           " case_failed exp %0d got %0d", want.failed, rsp_case_failed);
            end
         end
         stall_left = $urandom_range(0, stall_max);
      end
   end

   // whole store from reset: first, second, then rejection
   task automatic test_full_range();
      issue_request(CMD_PLACE, 0, END_W'(SLOT_COUNT), 0);
      issue_request(CMD_PLACE, 0, END_W'(SLOT_COUNT), 1023);
      issue_request(CMD_PLACE, 0, END_W'(SLOT_COUNT), 511);
   endtask

   // clear with all-ones fields resets store and flag
   task automatic test_clear_command();
      issue_request(CMD_CLEAR, '1, '1, '1);
      issue_request(CMD_PLACE, 0, END_W'(SLOT_COUNT), 512);
   endtask

   // empty ranges and ends past the store
   task automatic test_empty_and_clamped();
      issue_request(CMD_PLACE, 5, 5, 3);
      issue_request(CMD_PLACE, START_W'(SLOT_COUNT - 1), 0, 4);
      issue_request(CMD_PLACE, START_W'(SLOT_COUNT - 1), '1, 5);
      issue_request(CMD_PLACE, 100, 3000, 6);
   endtask

   // both resources busy in different slots of one range, no slot of that range with both
   task automatic test_split_conflict();
      issue_request(CMD_CLEAR, 0, 0, 0);
      issue_request(CMD_PLACE, 0, 2, 10);
      issue_request(CMD_PLACE, 1, 6, 11);
      issue_request(CMD_PLACE, 8, 10, 12);
      issue_request(CMD_PLACE, 5, 9, 13);
      issue_request(CMD_PLACE, 6, 8, 14);
   endtask

   // back-to-back overlaps, then a full drain before more traffic
   task automatic test_drain_pause();
      gap_max = 0;
      issue_request(CMD_CLEAR, 0, 0, 0);
      issue_request(CMD_PLACE, 20, 40, 100);
      issue_request(CMD_PLACE, 30, 50, 101);
      issue_request(CMD_PLACE, 35, 45, 102);
      wait_for_drain();
      issue_request(CMD_PLACE, 44, 60, 103);
      gap_max = 6;
   endtask

   // well-formed cases: clear, then intervals sorted by start
   task automatic test_sorted_cases(input int unsigned item_goal);
      int unsigned sent;
      int unsigned case_len;
      int unsigned cursor;
      int unsigned lo;
      int unsigned hi;
      sent = 0;
      while (sent < item_goal) begin
         gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
         stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         issue_request(CMD_CLEAR, START_W'($urandom), END_W'($urandom), ID_W'($urandom));
         sent++;
         case_len = $urandom_range(4, 30);
         cursor   = $urandom_range(0, 200);
         for (int unsigned k = 0; k < case_len; k++) begin
            lo = cursor + $urandom_range(0, 6);
            if (lo > SLOT_COUNT - 1) lo = SLOT_COUNT - 1;
            hi = lo + draw_span_length();
            if (hi > SLOT_COUNT) hi = SLOT_COUNT;
            if ($urandom_range(0, 31) == 0) hi = $urandom_range(SLOT_COUNT, 4095);
            issue_request(CMD_PLACE, START_W'(lo), END_W'(hi), ID_W'($urandom_range(0, 1023)));
            cursor = lo;
            sent++;
         end
         if ($urandom_range(0, 4) == 0) wait_for_drain();
      end
      gap_max   = 6;
      stall_max = 6;
   endtask

   // unsorted starts, backward ranges and stray clears
   task automatic test_random_noise(input int unsigned count);
      logic        cmd;
      int unsigned lo;
      int unsigned hi;
      int unsigned r;
      for (int unsigned k = 0; k < count; k++) begin
         cmd = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_PLACE;
         lo  = $urandom_range(0, SLOT_COUNT - 1);
         r   = $urandom_range(0, 9);
         if (r < 6) hi = lo + draw_span_length();
         else if (r < 8) hi = $urandom_range(0, lo);
         else hi = $urandom_range(0, 4095);
         issue_request(cmd, START_W'(lo), END_W'(hi), ID_W'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      clear_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_full_range();
      test_clear_command();
      test_empty_and_clamped();
      test_split_conflict();
      test_drain_pause();
      test_sorted_cases(340);
      test_random_noise(85);

      // drain and let a trailing clear sweep finish
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (4200) @(posedge clock);

      if (error_count == 0 && expected_placements.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tria_pkg.sv
rtl/core/tria_datapath.sv
rtl/core/tria_ctrl.sv
rtl/core/two_resource_interval_assigner.sv
rtl/core/tria_checker.sv
test/two_resource_interval_assigner_tb.sv
